// ===== rtl/lbsb_pkg.sv =====
// ----------------------------------------------------------------------------
// lbsb_pkg
// Shared widths, fixed-point helpers and the coefficient tables of the
// quartic box-spline basis.
// ----------------------------------------------------------------------------
package lbsb_pkg;

  localparam int FracBits   = 16;
  localparam int CoordW     = 17;
  localparam int OutW       = 20;
  localparam int IdxW       = 4;
  localparam int NumBasis   = 12;
  localparam int NumM4      = 15;
  localparam int NumM3      = 10;
  localparam int NumM2      = 6;
  // monomials stay below 2^(4*CoordW-3*FracBits)+1 for full-range inputs
  localparam int MonoW      = 22;
  localparam int SumW       = 32;
  // sums beyond +-2^MagW saturate anyway, so the divider sees MagW bits
  localparam int MagW       = 23;
  localparam int RcpShift   = 27;
  localparam int RcpW       = 24;
  localparam logic [RcpW-1:0] Recip12 =
    RcpW'(((64'd1 << RcpShift) + 64'd11) / 64'd12);
  localparam int SatHi      = 524287;
  localparam int SatLo      = -524288;

  typedef logic [MonoW-1:0] mono_t;
  typedef logic signed [7:0] coef_t;
  typedef logic signed [SumW-1:0] sum_t;
  typedef logic signed [OutW-1:0] res_t;
  typedef logic [MagW-1:0] mag_t;

  // rounded fixed-point product; operands stay below 2^MonoW
  function automatic mono_t fx_mul(input mono_t a, input mono_t b);
    logic [2*MonoW-1:0] p;
    p = (2*MonoW)'(a) * (2*MonoW)'(b);
    p = p + (2*MonoW)'(1 << (FracBits - 1));
    return MonoW'(p >> FracBits);
  endfunction

  // sign and magnitude of a+b+6, clamped where the quotient saturates
  function automatic logic [MagW:0] div12_prep(input sum_t a, input sum_t b);
    logic signed [SumW:0] m;
    m = (SumW+1)'(a) + (SumW+1)'(b) + (SumW+1)'(6);
    if (m > (SumW+1)'((1 << MagW) - 1)) return {1'b0, {MagW{1'b1}}};
    if (m < -(SumW+1)'(1 << MagW)) return {1'b1, {MagW{1'b1}}};
    if (m[SumW]) return {1'b1, MagW'(~m)};
    return {1'b0, MagW'(m)};
  endfunction

  // floor division by 12 of the prepared value, with saturation
  function automatic res_t div12_fin(input logic neg, input mag_t mag);
    logic [MagW+RcpW-1:0]    pr;
    logic [OutW-1:0]         q;
    logic signed [OutW+1:0]  s;
    pr = (MagW+RcpW)'(mag) * (MagW+RcpW)'(Recip12);
    q  = OutW'(pr >> RcpShift);
    s  = $signed({2'b00, q});
    if (neg) s = -s - (OutW+2)'(1);
    if (s > (OutW+2)'(SatHi)) return res_t'(SatHi);
    if (s < (OutW+2)'(SatLo)) return res_t'(SatLo);
    return res_t'(s);
  endfunction

  localparam coef_t ValTab [NumBasis][NumM4] = '{
    '{1,2,0,0,0,0,0,0,0,0,0,0,0,0,0},
    '{1,0,2,0,0,0,0,0,0,0,0,0,0,0,0},
    '{1,6,2,12,6,0,6,6,0,0,1,2,0,0,0},
    '{6,24,24,24,60,24,8,36,36,8,1,6,12,6,1},
    '{1,2,6,0,6,12,0,0,6,6,0,0,0,2,1},
    '{0,0,0,0,0,0,2,0,0,0,1,0,0,0,0},
    '{1,8,6,24,36,12,24,60,36,6,6,24,24,8,1},
    '{1,6,8,12,36,24,6,36,60,24,1,8,24,24,6},
    '{0,0,0,0,0,0,0,0,0,2,0,0,0,0,1},
    '{0,0,0,0,0,0,0,0,0,0,1,2,0,0,0},
    '{0,0,0,0,0,0,2,6,6,2,1,6,12,6,1},
    '{0,0,0,0,0,0,0,0,0,0,0,0,0,2,1}};

  localparam coef_t DvTab [NumBasis][NumM3] = '{
    '{-2,-6,0,0,0,0,0,0,0,0},
    '{-4,0,-6,0,0,0,0,0,0,0},
    '{2,6,0,-6,0,0,-2,0,0,0},
    '{0,-24,-12,-24,-48,-12,-4,-18,-12,-2},
    '{-2,-6,-12,0,-12,-18,0,0,-6,-4},
    '{0,0,0,6,0,0,2,0,0,0},
    '{4,24,18,24,48,12,0,12,12,2},
    '{2,6,12,-6,0,12,-2,-12,-12,0},
    '{0,0,0,0,0,0,0,0,0,-2},
    '{0,0,0,0,0,0,4,6,0,0},
    '{0,0,0,6,12,6,2,12,18,4},
    '{0,0,0,0,0,0,0,0,0,2}};

  localparam coef_t DwTab [NumBasis][NumM3] = '{
    '{-4,-6,0,0,0,0,0,0,0,0},
    '{-2,0,-6,0,0,0,0,0,0,0},
    '{-2,-12,-6,-18,-12,0,-4,-6,0,0},
    '{0,-12,-24,-12,-48,-24,-2,-12,-18,-4},
    '{2,0,6,0,0,-6,0,0,0,-2},
    '{0,0,0,0,0,0,-2,0,0,0},
    '{2,12,6,12,0,-6,0,-12,-12,-2},
    '{4,18,24,12,48,24,2,12,12,0},
    '{0,0,0,0,0,6,0,0,0,2},
    '{0,0,0,0,0,0,2,0,0,0},
    '{0,0,0,6,12,6,4,18,12,2},
    '{0,0,0,0,0,0,0,0,6,4}};

  localparam coef_t DvvTab [NumBasis][NumM2] = '{
    '{0,12,0,0,0,0}, '{12,0,12,0,0,0}, '{0,-24,0,0,0,0},
    '{-24,0,-24,12,12,0}, '{0,12,12,0,12,12}, '{0,12,0,0,0,0},
    '{12,0,12,-24,-24,0}, '{0,-24,-24,0,-24,-24}, '{0,0,0,0,0,0},
    '{0,0,0,12,12,0}, '{0,12,12,0,12,12}, '{0,0,0,0,0,0}};

  localparam coef_t DwwTab [NumBasis][NumM2] = '{
    '{12,12,0,0,0,0}, '{0,0,12,0,0,0}, '{0,12,12,12,12,0},
    '{-24,-24,0,0,12,12}, '{0,0,-24,0,0,0}, '{0,0,0,0,0,0},
    '{0,-24,-24,-24,-24,0}, '{12,12,0,0,-24,-24}, '{0,0,12,0,0,0},
    '{0,0,0,0,0,0}, '{0,12,12,12,12,0}, '{0,0,0,0,12,12}};

  localparam coef_t DvwTab [NumBasis][NumM2] = '{
    '{6,12,0,0,0,0}, '{6,0,12,0,0,0}, '{-6,-12,0,6,0,0},
    '{-12,0,0,6,24,6}, '{-6,0,-12,0,0,6}, '{0,0,0,-6,0,0},
    '{6,0,-12,-12,-24,-6}, '{6,-12,0,-6,-24,-12}, '{0,0,0,0,0,-6},
    '{0,0,0,6,0,0}, '{0,12,12,6,24,6}, '{0,0,0,0,0,6}};

endpackage

// ===== rtl/lbsb_mono.sv =====
// ----------------------------------------------------------------------------
// lbsb_mono
// Monomial pipeline: four stages of rounded products build every monomial
// of degree two, three and four in u, v, w, in the exact multiply order.
// ----------------------------------------------------------------------------
module lbsb_mono (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [lbsb_pkg::CoordW-1:0]   v_i,
  input  logic [lbsb_pkg::CoordW-1:0]   w_i,
  input  logic [lbsb_pkg::CoordW-1:0]   u_i,
  output logic                          valid_o,
  output lbsb_pkg::mono_t               m4_o [lbsb_pkg::NumM4],
  output lbsb_pkg::mono_t               m3_o [lbsb_pkg::NumM3],
  output lbsb_pkg::mono_t               m2_o [lbsb_pkg::NumM2]
);
  import lbsb_pkg::*;

  localparam int Deg    = 4;
  localparam int NumAll = NumM4 + NumM3 + NumM2;
  localparam int OpNone = 0;
  localparam int OpU    = 1;
  localparam int OpV    = 2;
  localparam int OpW    = 3;

  // operand of multiply step s for monomial idx in table order
  function automatic int opsel(input int idx, input int s);
    int deg, j, k, ea, eb, ec;
    deg = 2;
    j   = idx - NumM4 - NumM3;
    if (idx < NumM4) begin
      deg = 4;
      j   = idx;
    end else if (idx < NumM4 + NumM3) begin
      deg = 3;
      j   = idx - NumM4;
    end
    k  = 0;
    ea = 0;
    eb = 0;
    ec = 0;
    for (int a = deg; a >= 0; a--) begin
      for (int b = deg - a; b >= 0; b--) begin
        if (k == j) begin
          ea = a;
          eb = b;
          ec = deg - a - b;
        end
        k++;
      end
    end
    if (s < ea) return OpU;
    if (s < ea + eb) return OpV;
    if (s < ea + eb + ec) return OpW;
    return OpNone;
  endfunction

  function automatic mono_t step_mul(input mono_t p, input int sel,
                                     input logic [CoordW-1:0] u,
                                     input logic [CoordW-1:0] v,
                                     input logic [CoordW-1:0] w);
    mono_t r;
    case (sel)
      OpU:     r = fx_mul(p, mono_t'(u));
      OpV:     r = fx_mul(p, mono_t'(v));
      OpW:     r = fx_mul(p, mono_t'(w));
      default: r = p;
    endcase
    return r;
  endfunction

  mono_t                     p_q [Deg][NumAll];
  logic [CoordW-1:0]         u_q [Deg-1];
  logic [CoordW-1:0]         v_q [Deg-1];
  logic [CoordW-1:0]         w_q [Deg-1];
  logic [Deg-1:0]            vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Deg-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    u_q[0] <= u_i;
    v_q[0] <= v_i;
    w_q[0] <= w_i;
    for (int s = 1; s < Deg - 1; s++) begin
      u_q[s] <= u_q[s-1];
      v_q[s] <= v_q[s-1];
      w_q[s] <= w_q[s-1];
    end
    for (int i = 0; i < NumAll; i++) begin
      p_q[0][i] <= step_mul(mono_t'(1 << FracBits), opsel(i, 0), u_i, v_i, w_i);
      for (int s = 1; s < Deg; s++) begin
        p_q[s][i] <= step_mul(p_q[s-1][i], opsel(i, s),
                              u_q[s-1], v_q[s-1], w_q[s-1]);
      end
    end
  end

  assign valid_o = vld_q[Deg-1];
  always_comb begin
    for (int i = 0; i < NumM4; i++) m4_o[i] = p_q[Deg-1][i];
    for (int i = 0; i < NumM3; i++) m3_o[i] = p_q[Deg-1][NumM4 + i];
    for (int i = 0; i < NumM2; i++) m2_o[i] = p_q[Deg-1][NumM4 + NumM3 + i];
  end

endmodule

// ===== rtl/loop_box_spline_basis_eval.sv =====
// ----------------------------------------------------------------------------
// loop_box_spline_basis_eval
// Quartic box-spline basis of a regular Loop patch with first and second
// derivatives, twelve result beats per point.
// ----------------------------------------------------------------------------
// channel | handshake          | payload
// point   | start_i / busy_o   | bary_v_i, bary_w_i, bary_u_i
// result  | result_valid_o     | basis_index_o .. deriv_mixed_o, last_basis_o
// A point takes one result beat per basis function at the result port,
// set by the shared weighted-sum and divide-by-12 path. busy_o stays high
// after an accept while the gap counter runs down, so points enter back to
// back with their beats in a row. The first beat reaches the ports through
// four monomial stages, the hold register, then sum, prepare and scale.
// Reset clears valid bits and counters only; the receiver cannot stall.
// ----------------------------------------------------------------------------
module loop_box_spline_basis_eval (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [lbsb_pkg::CoordW-1:0]      bary_v_i,
  input  logic [lbsb_pkg::CoordW-1:0]      bary_w_i,
  input  logic [lbsb_pkg::CoordW-1:0]      bary_u_i,
  output logic                             result_valid_o,
  output logic [lbsb_pkg::IdxW-1:0]        basis_index_o,
  output logic signed [lbsb_pkg::OutW-1:0] basis_value_o,
  output logic signed [lbsb_pkg::OutW-1:0] deriv_v_o,
  output logic signed [lbsb_pkg::OutW-1:0] deriv_w_o,
  output logic signed [lbsb_pkg::OutW-1:0] deriv_vv_o,
  output logic signed [lbsb_pkg::OutW-1:0] deriv_ww_o,
  output logic signed [lbsb_pkg::OutW-1:0] deriv_mixed_o,
  output logic                             last_basis_o
);
  import lbsb_pkg::*;

  localparam int HalfM4 = (NumM4 + 1) / 2;
  localparam int HalfM3 = (NumM3 + 1) / 2;
  localparam int HalfM2 = (NumM2 + 1) / 2;

  logic [IdxW-1:0] gap_q;
  logic            acc;
  assign acc    = start_i && !busy_o;
  assign busy_o = gap_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (acc) begin
      gap_q <= IdxW'(NumBasis - 1);
    end else if (busy_o) begin
      gap_q <= gap_q - 1'b1;
    end
  end

  logic  mvld;
  mono_t m4 [NumM4];
  mono_t m3 [NumM3];
  mono_t m2 [NumM2];

  lbsb_mono u_mono (
    .clk_i, .rst_ni, .valid_i(acc),
    .v_i(bary_v_i), .w_i(bary_w_i), .u_i(bary_u_i),
    .valid_o(mvld), .m4_o(m4), .m3_o(m3), .m2_o(m2)
  );

  // hold monomials for the twelve beats of the point
  mono_t           h4_q [NumM4];
  mono_t           h3_q [NumM3];
  mono_t           h2_q [NumM2];
  logic            run_q;
  logic [IdxW-1:0] k_q;

  always_ff @(posedge clk_i) begin
    if (mvld) begin
      h4_q <= m4;
      h3_q <= m3;
      h2_q <= m2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      k_q   <= '0;
    end else if (mvld) begin
      run_q <= 1'b1;
      k_q   <= '0;
    end else if (run_q) begin
      if (k_q == IdxW'(NumBasis - 1)) begin
        run_q <= 1'b0;
        k_q   <= '0;
      end else begin
        k_q   <= k_q + 1'b1;
      end
    end
  end

  // stage A: weighted partial sums, two halves per field
  sum_t            a_q [2][6];
  sum_t            a_d [2][6];
  logic            av_q;
  logic [IdxW-1:0] ak_q;

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      for (int f = 0; f < 6; f++) a_d[h][f] = '0;
    end
    for (int i = 0; i < NumM4; i++) begin
      if (i < HalfM4) a_d[0][0] += sum_t'(ValTab[k_q][i]) * sum_t'(h4_q[i]);
      else            a_d[1][0] += sum_t'(ValTab[k_q][i]) * sum_t'(h4_q[i]);
    end
    for (int i = 0; i < NumM3; i++) begin
      if (i < HalfM3) begin
        a_d[0][1] += sum_t'(DvTab[k_q][i]) * sum_t'(h3_q[i]);
        a_d[0][2] += sum_t'(DwTab[k_q][i]) * sum_t'(h3_q[i]);
      end else begin
        a_d[1][1] += sum_t'(DvTab[k_q][i]) * sum_t'(h3_q[i]);
        a_d[1][2] += sum_t'(DwTab[k_q][i]) * sum_t'(h3_q[i]);
      end
    end
    for (int i = 0; i < NumM2; i++) begin
      if (i < HalfM2) begin
        a_d[0][3] += sum_t'(DvvTab[k_q][i]) * sum_t'(h2_q[i]);
        a_d[0][4] += sum_t'(DwwTab[k_q][i]) * sum_t'(h2_q[i]);
        a_d[0][5] += sum_t'(DvwTab[k_q][i]) * sum_t'(h2_q[i]);
      end else begin
        a_d[1][3] += sum_t'(DvvTab[k_q][i]) * sum_t'(h2_q[i]);
        a_d[1][4] += sum_t'(DwwTab[k_q][i]) * sum_t'(h2_q[i]);
        a_d[1][5] += sum_t'(DvwTab[k_q][i]) * sum_t'(h2_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    ak_q <= k_q;
  end

  // stage B: combine, round offset, clamp to sign and magnitude
  logic [MagW:0]   b_q [6];
  logic            bv_q;
  logic [IdxW-1:0] bk_q;

  always_ff @(posedge clk_i) begin
    for (int f = 0; f < 6; f++) b_q[f] <= div12_prep(a_q[0][f], a_q[1][f]);
    bk_q <= ak_q;
  end

  // stage C: scale and clamp
  res_t            r_q [6];
  logic            rv_q;
  logic [IdxW-1:0] rk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q <= 1'b0;
      bv_q <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      av_q <= run_q;
      bv_q <= av_q;
      rv_q <= bv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int f = 0; f < 6; f++) r_q[f] <= div12_fin(b_q[f][MagW], b_q[f][MagW-1:0]);
    rk_q <= bk_q;
  end

  assign result_valid_o = rv_q;
  assign basis_index_o  = rk_q;
  assign basis_value_o  = r_q[0];
  assign deriv_v_o      = r_q[1];
  assign deriv_w_o      = r_q[2];
  assign deriv_vv_o     = r_q[3];
  assign deriv_ww_o     = r_q[4];
  assign deriv_mixed_o  = r_q[5];
  assign last_basis_o   = rk_q == IdxW'(NumBasis - 1);

endmodule
